// File: hdl/lcdc_pkg.sv
// ----------------------------------------------------------------------------
// lcdc_pkg
// Types, codes and tables shared by the 4-bit character LCD controller and
// its checker.
// ----------------------------------------------------------------------------
package lcdc_pkg;

   // Display grid
   localparam int ROWS = 4;
   localparam int COLS = 20;

   // Request type codes
   localparam logic [2:0] REQ_TICK   = 3'd0;
   localparam logic [2:0] REQ_INIT   = 3'd1;
   localparam logic [2:0] REQ_CMD    = 3'd2;
   localparam logic [2:0] REQ_DATA   = 3'd3;
   localparam logic [2:0] REQ_CURSOR = 3'd4;

   // Configuration register indexes
   localparam logic [2:0] CSR_SETUP_TICKS    = 3'd0;
   localparam logic [2:0] CSR_PULSE_TICKS    = 3'd1;
   localparam logic [2:0] CSR_SETTLE_TICKS   = 3'd2;
   localparam logic [2:0] CSR_LONG_CMD_TICKS = 3'd3;
   localparam logic [2:0] CSR_POWER_ON_TICKS = 3'd4;
   localparam logic [2:0] CSR_INIT_GAP_LONG  = 3'd5;
   localparam logic [2:0] CSR_INIT_GAP_SHORT = 3'd6;
   localparam logic [2:0] CSR_TRANSLATE_MODE = 3'd7;

   // Init sequence bytes and nibbles
   localparam logic [3:0] NIB_WAKE        = 4'h3;
   localparam logic [3:0] NIB_4BIT        = 4'h2;
   localparam logic [7:0] CMD_FUNC_4BIT   = 8'h28;
   localparam logic [7:0] CMD_DISPLAY_OFF = 8'h08;
   localparam logic [7:0] CMD_CLEAR       = 8'h01;
   localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
   localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
   localparam logic [7:0] CMD_LONG_MAX    = 8'h03;
   localparam logic [7:0] CMD_SET_DDRAM   = 8'h80;
   localparam logic [7:0] ROW_ODD_OFFSET  = 8'h40;

   // Init step numbering: nibbles, then commands
   localparam logic [3:0] INIT_NONE      = 4'd0;
   localparam logic [3:0] INIT_NIB_FIRST = 4'd1;
   localparam logic [3:0] INIT_NIB_LAST  = 4'd4;
   localparam logic [3:0] INIT_CMD_FIRST = 4'd5;
   localparam logic [3:0] INIT_CMD_LAST  = 4'd9;

   // Win-1251 translation
   localparam logic [7:0] CP_CYR_FIRST = 8'hC0;
   localparam logic [7:0] CP_DEGREE    = 8'hB0;
   localparam logic [7:0] ROM_DEGREE   = 8'hDF;

   localparam logic [7:0] CYR_MAP [64] = '{
      8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
      8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
      8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
      8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'hAF, 8'hB0, 8'hB1, 8'hA2,
      8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
      8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
      8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
      8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
   };

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_POWER,
      PH_SETUP,
      PH_PULSE,
      PH_SETTLE,
      PH_GAP
   } lcdc_phase_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] value;
      logic [7:0] row;
      logic [7:0] col;
   } lcdc_req_type;

   typedef struct packed {
      logic       pin_rs;
      logic       pin_enable;
      logic [3:0] pin_data;
      logic       busy_res;
      logic       accepted;
   } lcdc_rsp_type;

   typedef struct packed {
      logic [7:0]  setup_ticks;
      logic [7:0]  pulse_ticks;
      logic [9:0]  settle_ticks;
      logic [15:0] long_cmd_ticks;
      logic [15:0] power_on_ticks;
      logic [15:0] init_gap_long;
      logic [9:0]  init_gap_short;
      logic        translate_mode;
   } lcdc_cfg_type;

   typedef struct packed {
      lcdc_phase_type phase;
      logic [15:0]    wait_count;
      logic [7:0]     held_byte;
      logic           held_rs;
      logic           low_pending;
      logic [3:0]     init_step;
      logic           long_pending;
      logic           enable_level;
      logic [3:0]     data_lines;
   } lcdc_state_type;

   // Nibble of an init step in the nibble range
   function automatic logic [3:0] init_nibble(input logic [3:0] step);
      return (step == INIT_NIB_LAST) ? NIB_4BIT : NIB_WAKE;
   endfunction

   // Command byte of an init step in the command range
   function automatic logic [7:0] init_cmd(input logic [3:0] step);
      logic [7:0] b;
      unique case (step)
         4'd5:    b = CMD_FUNC_4BIT;
         4'd6:    b = CMD_DISPLAY_OFF;
         4'd7:    b = CMD_CLEAR;
         4'd8:    b = CMD_ENTRY_MODE;
         default: b = CMD_DISPLAY_ON;
      endcase
      return b;
   endfunction

   // Win-1251 to LCD ROM code
   function automatic logic [7:0] translate_char(input logic [7:0] ch);
      logic [7:0] r;
      r = ch;
      if (ch >= CP_CYR_FIRST) begin
         r = CYR_MAP[ch[5:0]];
      end else if (ch == CP_DEGREE) begin
         r = ROM_DEGREE;
      end
      return r;
   endfunction

   // Start one nibble: data out, E low, setup count
   function automatic lcdc_state_type begin_nibble(input lcdc_state_type st,
                                                   input logic [3:0] nib,
                                                   input logic [7:0] setup);
      lcdc_state_type s;
      s = st;
      s.data_lines   = nib;
      s.enable_level = 1'b0;
      s.phase        = PH_SETUP;
      s.wait_count   = {8'd0, setup};
      return s;
   endfunction

   // Latch a byte and start its high nibble
   function automatic lcdc_state_type begin_byte(input lcdc_state_type st,
                                                 input logic [7:0] b,
                                                 input logic rs,
                                                 input logic [7:0] setup);
      lcdc_state_type s;
      s = st;
      s.held_byte    = b;
      s.held_rs      = rs;
      s.low_pending  = 1'b1;
      s.long_pending = !rs && (b <= CMD_LONG_MAX);
      return begin_nibble(s, b[7:4], setup);
   endfunction

endpackage

// File: hdl/char_lcd_nibble_controller_top.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_controller_top
// Character LCD controller for a 4-bit HD44780-style bus, driven by ticks.
// ----------------------------------------------------------------------------
// Usage:
//  Request channel (req_valid/req_stall/req_data) carries one item per
//  request: a 1 us tick, init, command byte, data character or set cursor.
//  Ticks advance the running sequence; other items leave time standing.
//  A request of types init..cursor arriving while busy is dropped with
//  accepted = 0.
//  Response channel (rsp_valid/rsp_stall/rsp_data) returns exactly one
//  response per request: the pin levels and busy flag after that request.
//  Each response is registered; one request is taken per cycle while
//  req_stall is low, since each one is a single update of the sequencer registers.
//  Results pass through an output register and a skid register, so a stall
//  on the response side is felt at req_stall only once both are full.
//  Configuration writes (csr_*) are registered and apply to the next
//  count that is loaded; write them while the block is idle.
//  Synchronous reset loads the register defaults, idles the sequencer with
//  all lines low and empties the response buffer.
// ----------------------------------------------------------------------------
module char_lcd_nibble_controller_top
   import lcdc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_valid,
   output logic         req_stall,
   input  lcdc_req_type req_data,
   // response channel
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output lcdc_rsp_type rsp_data,
   // configuration
   input  logic         csr_write,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   lcdc_cfg_type   cfg_ff;
   lcdc_state_type st_ff, st_in;
   lcdc_rsp_type   out_ff, skid_ff, rsp_in;
   logic           out_valid_ff, skid_valid_ff;
   logic           push, take, acc;
   logic [7:0]     row_cl, col_cl, row_off, cur_addr;

   // End of a byte: next init command or back to idle
   function automatic lcdc_state_type finish_byte(input lcdc_state_type st,
                                                  input lcdc_cfg_type cfg);
      lcdc_state_type s;
      s = st;
      if (st.init_step >= INIT_CMD_FIRST && st.init_step < INIT_CMD_LAST) begin
         s.init_step = st.init_step + 4'd1;
         s = begin_byte(s, init_cmd(s.init_step), 1'b0, cfg.setup_ticks);
      end else begin
         s.init_step    = INIT_NONE;
         s.phase        = PH_IDLE;
         s.enable_level = 1'b0;
         s.wait_count   = 16'd0;
      end
      return s;
   endfunction

   // A timed stage ran out
   function automatic lcdc_state_type stage_done(input lcdc_state_type st,
                                                 input lcdc_cfg_type cfg);
      lcdc_state_type s;
      logic           in_nib;
      s = st;
      in_nib = (st.init_step >= INIT_NIB_FIRST) && (st.init_step <= INIT_NIB_LAST);
      unique case (st.phase)
         PH_POWER: begin
            s.init_step = INIT_NIB_FIRST;
            s = begin_nibble(s, init_nibble(INIT_NIB_FIRST), cfg.setup_ticks);
         end
         PH_SETUP: begin
            s.enable_level = 1'b1;
            s.phase        = PH_PULSE;
            s.wait_count   = {8'd0, cfg.pulse_ticks};
         end
         PH_PULSE: begin
            s.enable_level = 1'b0;
            s.phase        = PH_SETTLE;
            s.wait_count   = {6'd0, cfg.settle_ticks};
         end
         PH_SETTLE: begin
            priority if (in_nib) begin
               s.phase      = PH_GAP;
               s.wait_count = (st.init_step == INIT_NIB_FIRST) ?
                              cfg.init_gap_long : {6'd0, cfg.init_gap_short};
            end else if (st.low_pending) begin
               s.low_pending = 1'b0;
               s = begin_nibble(s, st.held_byte[3:0], cfg.setup_ticks);
            end else if (st.long_pending) begin
               s.long_pending = 1'b0;
               s.phase        = PH_GAP;
               s.wait_count   = cfg.long_cmd_ticks;
            end else begin
               s = finish_byte(st, cfg);
            end
         end
         PH_GAP: begin
            if (in_nib) begin
               s.init_step = st.init_step + 4'd1;
               if (s.init_step <= INIT_NIB_LAST) begin
                  s = begin_nibble(s, init_nibble(s.init_step), cfg.setup_ticks);
               end else begin
                  s = begin_byte(s, init_cmd(INIT_CMD_FIRST), 1'b0, cfg.setup_ticks);
               end
            end else begin
               s = finish_byte(st, cfg);
            end
         end
         default: s.phase = PH_IDLE;
      endcase
      return s;
   endfunction

   // Handshakes
   assign push      = req_valid && !req_stall;
   assign take      = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // Cursor address: clamp, then row offset plus column
   always_comb begin
      row_cl   = (req_data.row >= 8'(ROWS)) ? 8'(ROWS - 1) : req_data.row;
      col_cl   = (req_data.col >= 8'(COLS)) ? 8'(COLS - 1) : req_data.col;
      row_off  = (row_cl[0] ? ROW_ODD_OFFSET : 8'd0) +
                 ((row_cl >= 8'd2) ? 8'(COLS) : 8'd0);
      cur_addr = CMD_SET_DDRAM | (row_off + col_cl);
   end

   // Sequencer next state
   always_comb begin
      st_in = st_ff;
      acc   = 1'b0;
      if (push) begin
         priority if (req_data.req_type == REQ_TICK) begin
            if (st_ff.phase != PH_IDLE) begin
               if (st_ff.wait_count <= 16'd1) begin
                  st_in = stage_done(st_ff, cfg_ff);
               end else begin
                  st_in.wait_count = st_ff.wait_count - 16'd1;
               end
            end
         end else if (req_data.req_type <= REQ_CURSOR && st_ff.phase == PH_IDLE) begin
            acc = 1'b1;
            priority if (req_data.req_type == REQ_INIT) begin
               st_in.held_rs      = 1'b0;
               st_in.data_lines   = 4'd0;
               st_in.enable_level = 1'b0;
               st_in.low_pending  = 1'b0;
               st_in.long_pending = 1'b0;
               st_in.init_step    = INIT_NONE;
               st_in.phase        = PH_POWER;
               st_in.wait_count   = cfg_ff.power_on_ticks;
            end else if (req_data.req_type == REQ_CMD) begin
               st_in = begin_byte(st_ff, req_data.value, 1'b0, cfg_ff.setup_ticks);
            end else if (req_data.req_type == REQ_DATA) begin
               st_in = begin_byte(st_ff,
                                  cfg_ff.translate_mode ?
                                  translate_char(req_data.value) : req_data.value,
                                  1'b1, cfg_ff.setup_ticks);
            end else begin
               st_in = begin_byte(st_ff, cur_addr, 1'b0, cfg_ff.setup_ticks);
            end
         end else begin
            acc = 1'b0;
         end
      end
   end

   // Response built from the state after this request
   always_comb begin
      rsp_in.pin_rs     = st_in.held_rs;
      rsp_in.pin_enable = st_in.enable_level;
      rsp_in.pin_data   = st_in.data_lines;
      rsp_in.busy_res   = (st_in.phase != PH_IDLE);
      rsp_in.accepted   = acc;
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '{phase: PH_IDLE, default: '0};
      end else begin
         st_ff <= st_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setup_ticks    <= 8'd2;
         cfg_ff.pulse_ticks    <= 8'd2;
         cfg_ff.settle_ticks   <= 10'd100;
         cfg_ff.long_cmd_ticks <= 16'd2000;
         cfg_ff.power_on_ticks <= 16'd50000;
         cfg_ff.init_gap_long  <= 16'd5000;
         cfg_ff.init_gap_short <= 10'd200;
         cfg_ff.translate_mode <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SETUP_TICKS:    cfg_ff.setup_ticks    <= csr_wdata[7:0];
            CSR_PULSE_TICKS:    cfg_ff.pulse_ticks    <= csr_wdata[7:0];
            CSR_SETTLE_TICKS:   cfg_ff.settle_ticks   <= csr_wdata[9:0];
            CSR_LONG_CMD_TICKS: cfg_ff.long_cmd_ticks <= csr_wdata;
            CSR_POWER_ON_TICKS: cfg_ff.power_on_ticks <= csr_wdata;
            CSR_INIT_GAP_LONG:  cfg_ff.init_gap_long  <= csr_wdata;
            CSR_INIT_GAP_SHORT: cfg_ff.init_gap_short <= csr_wdata[9:0];
            CSR_TRANSLATE_MODE: cfg_ff.translate_mode <= csr_wdata[0];
            default:            cfg_ff.translate_mode <= cfg_ff.translate_mode;
         endcase
      end
   end

   // Output and skid valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         if (out_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end
   end

   // Output and skid payload
   always_ff @(posedge clock) begin
      if (take) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (push) begin
            out_ff <= rsp_in;
         end
      end else if (push) begin
         if (out_valid_ff) begin
            skid_ff <= rsp_in;
         end else begin
            out_ff <= rsp_in;
         end
      end
   end

endmodule

// File: hdl/lcdc_checker.sv
// ----------------------------------------------------------------------------
// lcdc_checker
// Port-level checks for the 4-bit character LCD controller.
// ----------------------------------------------------------------------------
module lcdc_checker
   import lcdc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input lcdc_rsp_type rsp_data
);

   // Reset empties the response buffer
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("response buffer not empty after reset");

   // Request side backs up only when a response is pending
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall without a pending response");

   // A taken request always starts a sequence
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.accepted |-> rsp_data.busy_res)
      else $error("accepted request left the block idle");

   // E is only high inside a sequence
   a_enable_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.pin_enable |-> rsp_data.busy_res)
      else $error("enable high while idle");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

bind char_lcd_nibble_controller_top lcdc_checker u_lcdc_checker (.*);
